### hw/rtl/tcc_pkg.sv
// Shared types, codes and constants of the text console cursor engine.
`default_nettype none
package tcc_pkg;

    // input func codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_KBD   = 2'd2;

    // control characters
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_SPACE = 8'd32;

    // command opcodes
    localparam logic [2:0] OP_CLEAR    = 3'd0;
    localparam logic [2:0] OP_GLYPH    = 3'd1;
    localparam logic [2:0] OP_CURSOR   = 3'd2;
    localparam logic [2:0] OP_SCROLL   = 3'd3;
    localparam logic [2:0] OP_CLEARROW = 3'd4;

    // config register indexes
    localparam logic [1:0] CFG_NUM_COLS    = 2'd0;
    localparam logic [1:0] CFG_NUM_ROWS    = 2'd1;
    localparam logic [1:0] CFG_BLINK_TICKS = 2'd2;

    localparam logic [8:0]  NUM_COLS_RESET    = 9'd80;
    localparam logic [7:0]  NUM_ROWS_RESET    = 8'd25;
    localparam logic [15:0] BLINK_TICKS_RESET = 16'd100;

    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 128;
    localparam int QUEUE_DEPTH  = 4;

    typedef enum logic [2:0] {
        K_CHAR,
        K_NL,
        K_TAB,
        K_BS,
        K_TICK,
        K_KBD
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic [23:0] color;
    } t_job;

    typedef struct packed {
        logic [8:0]  num_cols;
        logic [7:0]  num_rows;
        logic [15:0] blink_ticks;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  op;
        logic [6:0]  row;
        logic [7:0]  col;
        logic [7:0]  glyph;
        logic [23:0] glyph_color;
        logic        cursor_on;
        logic        last;
    } t_cmd;

endpackage
`default_nettype wire

### hw/rtl/tcc_front.sv
// Front stage: accepts input items and classifies them into jobs.
`default_nettype none
module tcc_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [1:0]   i_func,
    input  wire logic [7:0]   i_ch,
    input  wire logic [23:0]  i_color,
    output logic              o_job_valid,
    input  wire logic         i_job_ready,
    output tcc_pkg::t_job     o_job
);
    import tcc_pkg::*;

    logic r_valid;
    t_job r_job;
    t_kind n_kind;

    assign o_ready     = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_comb begin
        case (i_func)
            FUNC_WRITE: begin
                case (i_ch)
                    CH_NL:   n_kind = K_NL;
                    CH_TAB:  n_kind = K_TAB;
                    CH_BS:   n_kind = K_BS;
                    default: n_kind = K_CHAR;
                endcase
            end
            FUNC_TICK: n_kind = K_TICK;
            default:   n_kind = K_KBD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            // unused func code is dropped here
            r_valid <= i_valid && (i_func inside {FUNC_WRITE, FUNC_TICK, FUNC_KBD});
            r_job.kind  <= n_kind;
            r_job.ch    <= i_ch;
            r_job.color <= i_color;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/tcc_queue.sv
// Short job queue between the front and back stages.
`default_nettype none
module tcc_queue #(
    parameter int DEPTH = tcc_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire tcc_pkg::t_job  i_push_job,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready,
    output tcc_pkg::t_job       o_pop_job
);
    import tcc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CNTW-1:0] r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != CNTW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rptr];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wptr] <= i_push_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wptr <= ptr_inc(r_wptr);
            if (pop)  r_rptr <= ptr_inc(r_rptr);
            if (push && !pop)      r_count <= CNTW'(r_count + 1'b1);
            else if (pop && !push) r_count <= CNTW'(r_count - 1'b1);
        end
    end

endmodule
`default_nettype wire

### hw/rtl/tcc_back.sv
// Back stage: cursor and blink state, command sequencer and output register.
`default_nettype none
module tcc_back #(
    parameter int MAX_COLS = tcc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tcc_pkg::DEF_MAX_ROWS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tcc_pkg::t_cfg  i_cfg,
    input  wire logic           i_job_valid,
    output logic                o_job_ready,
    input  wire tcc_pkg::t_job  i_job,
    output logic                o_cmd_valid,
    input  wire logic           i_cmd_ready,
    output tcc_pkg::t_cmd       o_cmd
);
    import tcc_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_GLYPH,
        S_SCROLL,
        S_CLRROW,
        S_BSCLR,
        S_CURSOR
    } t_state;

    t_state        r_state;
    t_kind         r_kind;
    logic [7:0]    r_ch;
    logic [23:0]   r_color;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [2:0]    r_cnt;
    logic          r_more;
    logic [15:0]   r_blink;
    logic          r_shown;
    logic          r_ov;
    t_cmd          r_cmd;

    logic [CW:0]   eff_cols;
    logic [RW:0]   eff_rows;
    logic [15:0]   eff_blink;
    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;
    logic [CW:0]   lc_full;
    logic [RW:0]   lr_full;
    logic [CW-1:0] last_col;
    logic [RW-1:0] last_row;
    logic [RW-1:0] row_c;
    logic [CW-1:0] col_c;
    logic          wrap;
    logic          row_over;
    logic          narrow;
    logic          more;
    logic          can_emit;
    logic          emit_go;
    logic          emitting;
    t_cmd          e_cmd;

    // out-of-range register values are saturated
    always_comb begin
        if (i_cfg.num_cols == '0)                eff_cols = (CW+1)'(1);
        else if (i_cfg.num_cols > 9'(MAX_COLS)) eff_cols = (CW+1)'(MAX_COLS);
        else                                     eff_cols = i_cfg.num_cols[CW:0];
        if (i_cfg.num_rows == '0)                eff_rows = (RW+1)'(1);
        else if (i_cfg.num_rows > 8'(MAX_ROWS)) eff_rows = (RW+1)'(MAX_ROWS);
        else                                     eff_rows = i_cfg.num_rows[RW:0];
        eff_blink = (i_cfg.blink_ticks == '0) ? 16'd1 : i_cfg.blink_ticks;
    end

    assign lc_full  = eff_cols - (CW+1)'(1);
    assign lr_full  = eff_rows - (RW+1)'(1);
    assign last_col = lc_full[CW-1:0];
    assign last_row = lr_full[RW-1:0];
    assign row_c    = ({1'b0, r_row} >= eff_rows) ? last_row : r_row;
    assign col_c    = ({1'b0, r_col} >= eff_cols) ? last_col : r_col;
    assign col_inc  = {1'b0, r_col} + (CW+1)'(1);
    assign row_inc  = {1'b0, r_row} + (RW+1)'(1);
    assign wrap     = (col_inc >= eff_cols);
    assign row_over = (row_inc >= eff_rows);
    assign narrow   = (eff_cols < (CW+1)'(4));
    // another tab space follows unless the count is spent or a narrow row wrapped
    assign more     = (r_kind == K_TAB) && (r_cnt != 3'd1) && !(wrap && narrow);

    assign can_emit    = !r_ov || i_cmd_ready;
    assign emit_go     = emitting && can_emit;
    assign o_job_ready = (r_state == S_IDLE);
    assign o_cmd_valid = r_ov;
    assign o_cmd       = r_cmd;

    always_comb begin
        e_cmd    = '0;
        emitting = 1'b1;
        case (r_state)
            S_CLEAR, S_BSCLR: begin
                e_cmd.op  = OP_CLEAR;
                e_cmd.row = 7'(r_row);
                e_cmd.col = 8'(r_col);
            end
            S_GLYPH: begin
                e_cmd.op          = OP_GLYPH;
                e_cmd.row         = 7'(r_row);
                e_cmd.col         = 8'(r_col);
                e_cmd.glyph       = (r_kind == K_TAB) ? CH_SPACE : r_ch;
                e_cmd.glyph_color = r_color;
            end
            S_SCROLL: e_cmd.op = OP_SCROLL;
            S_CLRROW: begin
                e_cmd.op  = OP_CLEARROW;
                e_cmd.row = 7'(last_row);
            end
            S_CURSOR: begin
                e_cmd.op        = OP_CURSOR;
                e_cmd.row       = 7'(r_row);
                e_cmd.col       = 8'(r_col);
                e_cmd.cursor_on = r_shown;
                e_cmd.last      = 1'b1;
            end
            default: emitting = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) r_cmd <= e_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_blink <= BLINK_TICKS_RESET;
            r_shown <= 1'b1;
            r_ov    <= 1'b0;
            r_more  <= 1'b0;
        end else begin
            if (emit_go)          r_ov <= 1'b1;
            else if (i_cmd_ready) r_ov <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_kind  <= i_job.kind;
                        r_ch    <= i_job.ch;
                        r_color <= i_job.color;
                        r_row   <= row_c;
                        r_col   <= col_c;
                        r_cnt   <= 3'd4 - {1'b0, col_c[1:0]};
                        case (i_job.kind)
                            K_TICK: begin
                                if (r_blink > 16'd1) begin
                                    r_blink <= r_blink - 16'd1;
                                end else begin
                                    r_blink <= eff_blink;
                                    r_shown <= !r_shown;
                                    r_state <= S_CURSOR;
                                end
                            end
                            K_KBD: begin
                                r_blink <= eff_blink;
                                r_shown <= 1'b1;
                                r_state <= S_CURSOR;
                            end
                            default: r_state <= S_CLEAR;
                        endcase
                    end
                end
                S_CLEAR: begin
                    if (can_emit) begin
                        case (r_kind)
                            K_NL: begin
                                r_col <= '0;
                                if (row_over) begin
                                    r_more  <= 1'b0;
                                    r_state <= S_SCROLL;
                                end else begin
                                    r_row   <= row_inc[RW-1:0];
                                    r_state <= S_CURSOR;
                                end
                            end
                            K_BS: begin
                                if (r_col == '0 && r_row == '0) begin
                                    r_state <= S_CURSOR;   // top left: no move
                                end else begin
                                    if (r_col == '0) begin
                                        r_row <= RW'(r_row - 1'b1);
                                        r_col <= last_col;
                                    end else begin
                                        r_col <= CW'(r_col - 1'b1);
                                    end
                                    r_state <= S_BSCLR;
                                end
                            end
                            default: r_state <= S_GLYPH;
                        endcase
                    end
                end
                S_GLYPH: begin
                    if (can_emit) begin
                        r_cnt <= 3'(r_cnt - 3'd1);
                        if (wrap) begin
                            r_col <= '0;
                            if (row_over) begin
                                r_more  <= more;
                                r_state <= S_SCROLL;
                            end else begin
                                r_row   <= row_inc[RW-1:0];
                                r_state <= more ? S_CLEAR : S_CURSOR;
                            end
                        end else begin
                            r_col   <= col_inc[CW-1:0];
                            r_state <= more ? S_CLEAR : S_CURSOR;
                        end
                    end
                end
                S_SCROLL: begin
                    if (can_emit) r_state <= S_CLRROW;
                end
                S_CLRROW: begin
                    if (can_emit) begin
                        r_row   <= last_row;
                        r_col   <= '0;
                        r_state <= r_more ? S_CLEAR : S_CURSOR;
                    end
                end
                S_BSCLR: begin
                    if (can_emit) r_state <= S_CURSOR;
                end
                S_CURSOR: begin
                    if (can_emit) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### hw/rtl/text_console_cursor_engine.sv
// Top level of the text console cursor engine: config registers and stage wiring.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid/s_axis_tready    tuser func, tdata ch|color
//  m_axis   out  m_axis_tvalid/m_axis_tready    tuser op, tdata cell command, tlast
//  cfg      in   i_cfg_we (no wait)             i_cfg_addr, i_cfg_wdata
//
// One command leaves per cycle while m_axis_tready is high and the back sequencer,
// which sets the rate, has one to send. It dispatches each item, then sends its
// commands: a plain character sends clear, glyph, cursor; a scroll adds scroll and
// clear-row; a tab, a clear and a glyph per space. Ticks that only count down send none.
// Reset is synchronous, active low: cursor at 0,0, visible, blink count 100.
// Front and back are decoupled by a 4-entry job queue, and the output register
// lets the sequencer stop while a command waits on m_axis_tready.
`default_nettype none
module text_console_cursor_engine #(
    parameter int MAX_COLS = tcc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tcc_pkg::DEF_MAX_ROWS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input items
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,   // ch[7:0], color[31:8]
    input  wire logic [1:0]   s_axis_tuser,   // func[1:0]
    // drawing commands
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [47:0]       m_axis_tdata,   // row[6:0], col[14:7], glyph[22:15],
                                              // glyph_color[46:23], cursor_on[47]
    output logic [2:0]        m_axis_tuser,   // op[2:0]
    output logic              m_axis_tlast,
    // configuration writes
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_addr,
    input  wire logic [15:0]  i_cfg_wdata
);
    import tcc_pkg::*;

    t_cfg r_cfg;
    t_job front_job;
    t_job queue_job;
    t_cmd cmd;
    logic front_valid;
    logic queue_ready;
    logic queue_valid;
    logic back_ready;

    // registers; an index past the list is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_cols    <= NUM_COLS_RESET;
            r_cfg.num_rows    <= NUM_ROWS_RESET;
            r_cfg.blink_ticks <= BLINK_TICKS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_NUM_COLS:    r_cfg.num_cols    <= i_cfg_wdata[8:0];
                CFG_NUM_ROWS:    r_cfg.num_rows    <= i_cfg_wdata[7:0];
                CFG_BLINK_TICKS: r_cfg.blink_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    tcc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_func      (s_axis_tuser),
        .i_ch        (s_axis_tdata[7:0]),
        .i_color     (s_axis_tdata[31:8]),
        .o_job_valid (front_valid),
        .i_job_ready (queue_ready),
        .o_job       (front_job)
    );

    tcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (queue_ready),
        .i_push_job   (front_job),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (back_ready),
        .o_pop_job    (queue_job)
    );

    tcc_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (queue_valid),
        .o_job_ready (back_ready),
        .i_job       (queue_job),
        .o_cmd_valid (m_axis_tvalid),
        .i_cmd_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    assign m_axis_tdata = {cmd.cursor_on, cmd.glyph_color, cmd.glyph, cmd.col, cmd.row};
    assign m_axis_tuser = cmd.op;
    assign m_axis_tlast = cmd.last;

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench of the text console cursor engine: directed and random items.
`default_nettype none
module tb;
    import tcc_pkg::*;

    // func code that the block must ignore
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // cycles without any handshake before the run is called hung
    localparam int STALL_LIMIT = 2000;
    // cycles allowed after the last command for items that draw nothing
    localparam int SETTLE_CYCLES = 30;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_data = '0;   // ch[7:0], color[31:8]
    logic [1:0]  s_user = '0;   // func[1:0]
    logic        m_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    wire logic        s_axis_tready;
    wire logic        m_axis_tvalid;
    wire logic [47:0] m_axis_tdata;   // row[6:0], col[14:7], glyph[22:15],
                                      // glyph_color[46:23], cursor_on[47]
    wire logic [2:0]  m_axis_tuser;   // op[2:0]
    wire logic        m_axis_tlast;

    text_console_cursor_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Console model: register copies and cursor state
    // ------------------------------------------------------------------
    int unsigned reg_cols, reg_rows, reg_blink;
    int unsigned cur_row, cur_col, blink_left;
    logic        cursor_shown;

    t_cmd pending_cmds[$];   // drawing commands still owed by the block
    int   mismatch_count = 0;
    bit   calm = 1'b0;       // no idling on either side while set

    function automatic int unsigned screen_cols();
        if (reg_cols == 0) return 1;
        if (reg_cols > DEF_MAX_COLS) return DEF_MAX_COLS;
        return reg_cols;
    endfunction

    function automatic int unsigned screen_rows();
        if (reg_rows == 0) return 1;
        if (reg_rows > DEF_MAX_ROWS) return DEF_MAX_ROWS;
        return reg_rows;
    endfunction

    function automatic int unsigned blink_period();
        return (reg_blink == 0) ? 1 : reg_blink;
    endfunction

    function automatic void queue_cmd(logic [2:0] op, int unsigned row, int unsigned col,
                                      logic [7:0] glyph, logic [23:0] clr, logic on,
                                      logic fin);
        t_cmd c;
        c.op          = op;
        c.row         = row[6:0];
        c.col         = col[7:0];
        c.glyph       = glyph;
        c.glyph_color = clr;
        c.cursor_on   = on;
        c.last        = fin;
        pending_cmds.push_back(c);
    endfunction

    // Past the bottom row: scroll and blank the new last row.
    function automatic void scroll_past_bottom();
        if (cur_row < screen_rows()) return;
        queue_cmd(OP_SCROLL, 0, 0, 8'd0, 24'd0, 1'b0, 1'b0);
        queue_cmd(OP_CLEARROW, screen_rows() - 1, 0, 8'd0, 24'd0, 1'b0, 1'b0);
        cur_row = screen_rows() - 1;
        cur_col = 0;
    endfunction

    // Draw one glyph at the cursor and advance; returns 1 on a line wrap.
    function automatic bit place_glyph(logic [7:0] g, logic [23:0] clr);
        queue_cmd(OP_CLEAR, cur_row, cur_col, 8'd0, 24'd0, 1'b0, 1'b0);
        queue_cmd(OP_GLYPH, cur_row, cur_col, g, clr, 1'b0, 1'b0);
        cur_col++;
        if (cur_col >= screen_cols()) begin
            cur_row++;
            cur_col = 0;
            scroll_past_bottom();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void write_console_char(logic [7:0] ch, logic [23:0] clr);
        int unsigned spaces;
        if (ch == CH_NL) begin
            queue_cmd(OP_CLEAR, cur_row, cur_col, 8'd0, 24'd0, 1'b0, 1'b0);
            cur_row++;
            cur_col = 0;
            scroll_past_bottom();
        end else if (ch == CH_TAB) begin
            spaces = 4 - (cur_col & 3);
            for (int unsigned i = 0; i < spaces; i++) begin
                // a narrow screen stops the tab at its one wrap
                if (place_glyph(CH_SPACE, clr) && screen_cols() < 4) break;
            end
        end else if (ch == CH_BS) begin
            queue_cmd(OP_CLEAR, cur_row, cur_col, 8'd0, 24'd0, 1'b0, 1'b0);
            if (cur_col == 0) begin
                if (cur_row == 0) return;   // top left: nothing to step back to
                cur_row--;
                cur_col = screen_cols() - 1;
            end else begin
                cur_col--;
            end
            queue_cmd(OP_CLEAR, cur_row, cur_col, 8'd0, 24'd0, 1'b0, 1'b0);
        end else begin
            void'(place_glyph(ch, clr));
        end
    endfunction

    // Commands one accepted item causes, appended to pending_cmds.
    function automatic void plan_commands(logic [1:0] func, logic [7:0] ch, logic [23:0] clr);
        if (func == FUNC_UNUSED) return;
        // a shrunk screen pulls the cursor back inside
        if (cur_row >= screen_rows()) cur_row = screen_rows() - 1;
        if (cur_col >= screen_cols()) cur_col = screen_cols() - 1;
        if (func == FUNC_WRITE) begin
            write_console_char(ch, clr);
        end else if (func == FUNC_TICK) begin
            if (blink_left > 1) begin
                blink_left--;
                return;
            end
            blink_left   = blink_period();
            cursor_shown = ~cursor_shown;
        end else begin
            blink_left   = blink_period();
            cursor_shown = 1'b1;
        end
        queue_cmd(OP_CURSOR, cur_row, cur_col, 8'd0, 24'd0, cursor_shown, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Checking of the command stream
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_cmd want;
        if (i_rst_n && m_axis_tvalid && m_ready) begin
            if (pending_cmds.size() == 0) begin
                note_mismatch("unexpected command, op", 32'(m_axis_tuser), 0);
            end else begin
                want = pending_cmds.pop_front();
                if (m_axis_tuser !== want.op)
                    note_mismatch("op", 32'(m_axis_tuser), 32'(want.op));
                if (m_axis_tdata[6:0] !== want.row)
                    note_mismatch("row", 32'(m_axis_tdata[6:0]), 32'(want.row));
                if (m_axis_tdata[14:7] !== want.col)
                    note_mismatch("col", 32'(m_axis_tdata[14:7]), 32'(want.col));
                if (m_axis_tdata[22:15] !== want.glyph)
                    note_mismatch("glyph", 32'(m_axis_tdata[22:15]), 32'(want.glyph));
                if (m_axis_tdata[46:23] !== want.glyph_color)
                    note_mismatch("glyph_color", 32'(m_axis_tdata[46:23]),
                                  32'(want.glyph_color));
                if (m_axis_tdata[47] !== want.cursor_on)
                    note_mismatch("cursor_on", 32'(m_axis_tdata[47]), 32'(want.cursor_on));
                if (m_axis_tlast !== want.last)
                    note_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
            end
        end
    end

    // Command sink: stalls about a quarter of the cycles unless calm.
    always @(negedge i_clk)
        m_ready <= calm || ($urandom_range(99) >= 24);

    // Hang detection: any handshake or register write restarts the count.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("text_console_cursor_engine: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Offer one item, with random gaps before it, and model it once taken.
    task automatic push_item(input logic [1:0] func, input logic [7:0] ch,
                             input logic [23:0] clr);
        while (!calm && $urandom_range(99) < 24) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data  <= {clr, ch};
        s_user  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        plan_commands(func, ch, clr);
    endtask

    task automatic put_text(input logic [7:0] ch, input logic [23:0] clr);
        push_item(FUNC_WRITE, ch, clr);
    endtask

    // Stop offering items and wait for every owed command.
    task automatic drain_commands();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
    endtask

    // Drained plus room for trailing items that draw nothing.
    task automatic quiesce();
        drain_commands();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            CFG_NUM_COLS:    reg_cols  = 32'(value[8:0]);
            CFG_NUM_ROWS:    reg_rows  = 32'(value[7:0]);
            CFG_BLINK_TICKS: reg_blink = 32'(value);
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_screen(input int unsigned cols, input int unsigned rows,
                              input int unsigned blink);
        quiesce();
        write_reg(CFG_NUM_COLS, cols[15:0]);
        write_reg(CFG_NUM_ROWS, rows[15:0]);
        write_reg(CFG_BLINK_TICKS, blink[15:0]);
    endtask

    // Random mix; ignored items are not counted toward n.
    task automatic run_random(input int n, input int tick_pct, input int nl_pct,
                              input int tab_pct, input int bs_pct);
        int          taken;
        int          r;
        logic [1:0]  func;
        logic [7:0]  ch;
        logic [23:0] clr;
        taken = 0;
        while (taken < n) begin
            r   = $urandom_range(99);
            ch  = 8'($urandom_range(255));
            clr = 24'($urandom());
            if (r < 3) begin
                func = FUNC_UNUSED;
            end else if (r < 3 + tick_pct) begin
                func = FUNC_TICK;
            end else if (r < 8 + tick_pct) begin
                func = FUNC_KBD;
            end else begin
                func = FUNC_WRITE;
                r = $urandom_range(99);
                if (r < nl_pct) ch = CH_NL;
                else if (r < nl_pct + tab_pct) ch = CH_TAB;
                else if (r < nl_pct + tab_pct + bs_pct) ch = CH_BS;
            end
            push_item(func, ch, clr);
            if (func != FUNC_UNUSED) taken++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset screen 80x25: field extremes and every control character.
    task automatic test_reset_screen();
        put_text(CH_BS, 24'h000000);          // backspace at top left: no move
        put_text(8'h41, 24'h000000);
        put_text(8'hFF, 24'hFFFFFF);
        put_text(8'h00, 24'h5AA5C3);          // code 0 is an ordinary glyph
        put_text(CH_TAB, 24'h00FF00);         // col 3 -> 4
        put_text(CH_TAB, 24'hFF00FF);         // col 4 -> 8, four spaces
        put_text(CH_BS, 24'h123456);
        put_text(CH_NL, 24'hABCDEF);
        put_text(CH_BS, 24'h000001);          // col 0 wraps to end of row above
        push_item(FUNC_UNUSED, 8'hFF, 24'hFFFFFF);
        push_item(FUNC_TICK, 8'h00, 24'h000000);
        push_item(FUNC_KBD, 8'hA5, 24'h800000);
    endtask

    // 3x2 screen, zero blink count: cursor pulled in, narrow tabs, scrolls.
    task automatic test_narrow_screen();
        set_screen(3, 2, 0);
        push_item(FUNC_KBD, 8'h00, 24'h000000);
        push_item(FUNC_TICK, 8'h00, 24'h000000);   // fires every tick now
        push_item(FUNC_TICK, 8'h00, 24'h000000);
        put_text(CH_TAB, 24'h0000FF);              // from last column: one space
        put_text(8'h61, 24'h111111);
        put_text(8'h62, 24'h222222);
        put_text(8'h63, 24'h333333);               // wraps at bottom: scroll
        put_text(CH_NL, 24'h444444);               // newline at bottom: scroll
        put_text(CH_TAB, 24'h555555);              // three spaces then stop
        put_text(CH_BS, 24'h666666);
    endtask

    task automatic test_random_default();
        set_screen(80, 25, 100);
        run_random(35, 15, 10, 10, 10);
        drain_commands();                          // hold off until all drawn
        run_random(35, 15, 10, 10, 10);
    endtask

    // One column drives the cursor down to row 127 and scrolls there.
    task automatic test_single_column_fill();
        set_screen(1, 128, 0);
        run_random(130, 5, 5, 5, 5);
    endtask

    // Widest screen starting at the bottom row; no idling on either side.
    task automatic test_widest_screen();
        set_screen(256, 128, 65535);
        calm = 1'b1;
        run_random(80, 5, 5, 45, 15);
        quiesce();
        calm = 1'b0;
    endtask

    // Register values above the supported sizes are clipped.
    task automatic test_oversized_registers();
        set_screen(511, 255, 1);
        run_random(50, 15, 10, 20, 15);
    endtask

    // Zero sizes behave as a 1x1 screen.
    task automatic test_zero_registers();
        set_screen(0, 0, 2);
        run_random(40, 20, 15, 15, 15);
    endtask

    task automatic test_random_small_screens();
        repeat (3) begin
            set_screen($urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(0, 5));
            run_random(30, 20, 15, 15, 15);
        end
    endtask

    initial begin
        reg_cols     = 32'(NUM_COLS_RESET);
        reg_rows     = 32'(NUM_ROWS_RESET);
        reg_blink    = 32'(BLINK_TICKS_RESET);
        cur_row      = 0;
        cur_col      = 0;
        blink_left   = 32'(BLINK_TICKS_RESET);
        cursor_shown = 1'b1;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_screen();
        test_narrow_screen();
        test_random_default();
        test_single_column_fill();
        test_widest_screen();
        test_oversized_registers();
        test_zero_registers();
        test_random_small_screens();
        quiesce();

        if (pending_cmds.size() != 0)
            note_mismatch("commands never drawn", pending_cmds.size(), 0);
        if (mismatch_count == 0) begin
            $display("text_console_cursor_engine: match");
        end else begin
            $display("text_console_cursor_engine: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire
